// ===== design/tappc_pkg.sv =====
// Shared types, constants and saturation helpers of the three-axis PID position controller.
`default_nettype none

package tappc_pkg;

    // Field and register widths.
    localparam int FIELD_W      = 32;
    localparam int GAIN_W       = 31;
    localparam int TICK_W       = 17;
    localparam int PROD_W       = FIELD_W + GAIN_W;
    localparam int MUL_CNT_W    = 5;
    localparam int DRIVE_XY_W   = 16;
    localparam int DRIVE_TURN_W = 17;
    localparam int S_TDATA_W    = 5 * FIELD_W;
    localparam int M_TDATA_W    = 56;
    localparam int M_PAD_W      = M_TDATA_W - 2 * DRIVE_XY_W - DRIVE_TURN_W;
    localparam int ADDR_W       = 5;
    localparam int APB_DATA_W   = 32;

    // Register reset values.
    localparam logic [GAIN_W-1:0] KP_RESET      = 31'd131072;
    localparam logic [GAIN_W-1:0] KI_DT_RESET   = 31'd7;
    localparam logic [GAIN_W-1:0] KD_RATE_RESET = 31'd655360;
    localparam logic [TICK_W-1:0] TICK_RESET    = 17'd655;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_KP_X,
        REG_KI_DT_X,
        REG_KD_RATE_X,
        REG_KP_Y,
        REG_KI_DT_Y,
        REG_KD_RATE_Y,
        REG_TICK_PERIOD
    } reg_idx_t;

    // Gains and tick period as seen by the datapath.
    typedef struct packed {
        logic [GAIN_W-1:0] kp_x;
        logic [GAIN_W-1:0] ki_dt_x;
        logic [GAIN_W-1:0] kd_rate_x;
        logic [GAIN_W-1:0] kp_y;
        logic [GAIN_W-1:0] ki_dt_y;
        logic [GAIN_W-1:0] kd_rate_y;
        logic [TICK_W-1:0] tick_period;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEAD,
        ST_ERR,
        ST_LAUNCH,
        ST_PID,
        ST_HOLD
    } state_t;

    // Saturate a 64-bit signed value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a 64-bit signed value to plus or minus a positive limit.
    function automatic logic signed [63:0] clamp_sym(input logic signed [63:0] v,
                                                     input logic signed [63:0] lim);
        logic signed [63:0] r;
        if (v > lim) begin
            r = lim;
        end else if (v < -lim) begin
            r = -lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/tappc_ser_mul.sv =====
// Bit-serial shift-add multiplier: signed 32-bit operand times unsigned 31-bit gain.
`default_nettype none

module tappc_ser_mul (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [tappc_pkg::FIELD_W-1:0]  a,
    input  wire logic        [tappc_pkg::GAIN_W-1:0]   b,
    output logic                                       done,
    output logic signed [tappc_pkg::PROD_W-1:0]        product
);

    localparam int HI_W = tappc_pkg::FIELD_W + 2;
    localparam logic [tappc_pkg::MUL_CNT_W-1:0] LAST_STEP =
        tappc_pkg::MUL_CNT_W'(tappc_pkg::GAIN_W - 1);

    logic signed [tappc_pkg::FIELD_W-1:0] a_reg;
    logic        [tappc_pkg::GAIN_W-1:0]  b_reg;
    logic signed [HI_W-1:0]               hi_reg;
    logic        [tappc_pkg::GAIN_W-1:0]  lo_reg;
    logic        [tappc_pkg::MUL_CNT_W-1:0] cnt_reg;
    logic                                 busy_reg;
    logic                                 done_reg;

    logic signed [HI_W-1:0] addend;
    logic signed [HI_W-1:0] sum;

    // One multiplier bit per cycle, least significant first.
    always_comb begin
        addend = b_reg[0] ? {{2{a_reg[tappc_pkg::FIELD_W-1]}}, a_reg} : '0;
        sum    = hi_reg + addend;
    end

    // Control: busy for one step per gain bit, then a one-cycle done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == LAST_STEP);
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == LAST_STEP)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Partial product shifts right; its low bits collect in lo_reg.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= a;
            b_reg   <= b;
            hi_reg  <= '0;
            lo_reg  <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            hi_reg  <= {sum[HI_W-1], sum[HI_W-1:1]};
            lo_reg  <= {sum[0], lo_reg[tappc_pkg::GAIN_W-1:1]};
            b_reg   <= {1'b0, b_reg[tappc_pkg::GAIN_W-1:1]};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg[tappc_pkg::FIELD_W-1:0], lo_reg};

endmodule

`default_nettype wire

// ===== design/tappc_cfg.sv =====
// APB register file holding the loop gains and the tick period.
`default_nettype none

module tappc_cfg (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tappc_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [tappc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [tappc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                      pready,
    output tappc_pkg::cfg_t                           cfg
);

    tappc_pkg::cfg_t   cfg_reg;
    tappc_pkg::reg_idx_t idx;
    logic              wr_en;

    assign idx    = tappc_pkg::reg_idx_t'(paddr[tappc_pkg::ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // Register writes, masked to each register's width.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp_x        <= tappc_pkg::KP_RESET;
            cfg_reg.ki_dt_x     <= tappc_pkg::KI_DT_RESET;
            cfg_reg.kd_rate_x   <= tappc_pkg::KD_RATE_RESET;
            cfg_reg.kp_y        <= tappc_pkg::KP_RESET;
            cfg_reg.ki_dt_y     <= tappc_pkg::KI_DT_RESET;
            cfg_reg.kd_rate_y   <= tappc_pkg::KD_RATE_RESET;
            cfg_reg.tick_period <= tappc_pkg::TICK_RESET;
        end else if (wr_en) begin
            unique case (idx)
                tappc_pkg::REG_KP_X:        cfg_reg.kp_x      <= pwdata[tappc_pkg::GAIN_W-1:0];
                tappc_pkg::REG_KI_DT_X:     cfg_reg.ki_dt_x   <= pwdata[tappc_pkg::GAIN_W-1:0];
                tappc_pkg::REG_KD_RATE_X:   cfg_reg.kd_rate_x <= pwdata[tappc_pkg::GAIN_W-1:0];
                tappc_pkg::REG_KP_Y:        cfg_reg.kp_y      <= pwdata[tappc_pkg::GAIN_W-1:0];
                tappc_pkg::REG_KI_DT_Y:     cfg_reg.ki_dt_y   <= pwdata[tappc_pkg::GAIN_W-1:0];
                tappc_pkg::REG_KD_RATE_Y:   cfg_reg.kd_rate_y <= pwdata[tappc_pkg::GAIN_W-1:0];
                tappc_pkg::REG_TICK_PERIOD: cfg_reg.tick_period <= pwdata[tappc_pkg::TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (idx)
            tappc_pkg::REG_KP_X:        prdata = {1'b0, cfg_reg.kp_x};
            tappc_pkg::REG_KI_DT_X:     prdata = {1'b0, cfg_reg.ki_dt_x};
            tappc_pkg::REG_KD_RATE_X:   prdata = {1'b0, cfg_reg.kd_rate_x};
            tappc_pkg::REG_KP_Y:        prdata = {1'b0, cfg_reg.kp_y};
            tappc_pkg::REG_KI_DT_Y:     prdata = {1'b0, cfg_reg.ki_dt_y};
            tappc_pkg::REG_KD_RATE_Y:   prdata = {1'b0, cfg_reg.kd_rate_y};
            tappc_pkg::REG_TICK_PERIOD: prdata = {15'd0, cfg_reg.tick_period};
            default:                    prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/tappc_axis.sv =====
// One PID loop: three serial multipliers, integral clamp, output clamp and deadband.
`default_nettype none

module tappc_axis #(
    parameter int FRAC_BITS = 16,
    parameter int OUT_LIM   = 19661,
    parameter int INTEG_LIM = 16384,
    parameter int DEAD_BAND = 983
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic signed [tappc_pkg::FIELD_W-1:0]  err,
    input  wire logic        [tappc_pkg::GAIN_W-1:0]   kp,
    input  wire logic        [tappc_pkg::GAIN_W-1:0]   ki,
    input  wire logic        [tappc_pkg::GAIN_W-1:0]   kd,
    output logic                                       done,
    output logic signed [tappc_pkg::FIELD_W-1:0]       out
);

    localparam logic signed [63:0] OUT_LIM_S   = 64'(OUT_LIM);
    localparam logic signed [63:0] INTEG_LIM_S = 64'(INTEG_LIM);
    localparam logic signed [31:0] DEAD_BAND_S = 32'(DEAD_BAND);

    logic signed [31:0] integ_reg;
    logic signed [31:0] last_err_reg;
    logic               db_reg;
    logic signed [31:0] i1_reg;
    logic signed [63:0] pd_reg;
    logic               s1_reg;
    logic               done_reg;
    logic signed [31:0] out_reg;

    logic signed [31:0] diff;
    logic               in_band;
    logic               kp_done;
    logic               ki_done;
    logic               kd_done;
    logic               mul_done;
    logic signed [tappc_pkg::PROD_W-1:0] kp_prod;
    logic signed [tappc_pkg::PROD_W-1:0] ki_prod;
    logic signed [tappc_pkg::PROD_W-1:0] kd_prod;
    logic signed [63:0] kp_term;
    logic signed [63:0] ki_term;
    logic signed [63:0] kd_term;
    logic signed [63:0] i1_next;
    logic signed [63:0] out_next;

    // Derivative difference and deadband test on the incoming error.
    always_comb begin
        diff    = tappc_pkg::sat32(64'(err) - 64'(last_err_reg));
        in_band = (err > -DEAD_BAND_S) && (err < DEAD_BAND_S);
    end

    tappc_ser_mul u_mul_kp (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .a(err), .b(kp), .done(kp_done), .product(kp_prod)
    );

    tappc_ser_mul u_mul_ki (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .a(err), .b(ki), .done(ki_done), .product(ki_prod)
    );

    tappc_ser_mul u_mul_kd (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .a(diff), .b(kd), .done(kd_done), .product(kd_prod)
    );

    // The three products share one start and finish in the same cycle.
    assign mul_done = kp_done && ki_done && kd_done;

    // Floor-scaled terms and the two finishing stages.
    always_comb begin
        kp_term  = 64'(kp_prod) >>> FRAC_BITS;
        ki_term  = 64'(ki_prod) >>> FRAC_BITS;
        kd_term  = 64'(kd_prod) >>> FRAC_BITS;
        i1_next  = tappc_pkg::clamp_sym(64'(integ_reg) + ki_term, INTEG_LIM_S);
        out_next = tappc_pkg::clamp_sym(pd_reg + 64'(i1_reg), OUT_LIM_S);
    end

    // Loop state and stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            last_err_reg <= '0;
            s1_reg       <= 1'b0;
            done_reg     <= 1'b0;
        end else begin
            s1_reg   <= mul_done;
            done_reg <= s1_reg;
            if (start) begin
                last_err_reg <= err;
            end
            if (s1_reg) begin
                integ_reg <= db_reg ? 32'sd0 : i1_reg;
            end
        end
    end

    // Payload of the finishing stages.
    always_ff @(posedge aclk) begin
        if (start) begin
            db_reg <= in_band;
        end
        if (mul_done) begin
            i1_reg <= i1_next[31:0];
            pd_reg <= kp_term + kd_term;
        end
        if (s1_reg) begin
            out_reg <= db_reg ? 32'sd0 : out_next[31:0];
        end
    end

    assign done = done_reg;
    assign out  = out_reg;

endmodule

`default_nettype wire

// ===== design/three_axis_pid_position_controller_core.sv =====
// Top level: dead reckoning, error formation and three PID loops behind stream ports.
//
//  Port group   Dir   Beat contents
//  s_*          in    target_x, target_y, speed_x, speed_y, yaw_rate (32 bits each)
//  m_*          out   drive_x (16), drive_y (16), drive_turn (17)
//  p*           in    APB register writes and reads of gains and tick period
//
// Each beat is carried through before the next input beat is accepted: two
// 31-step bit-serial multiplies in series (dead reckoning, then the PID products,
// all three axes at once) plus error forming and clamping.
// Reset clears the position estimates, integrals and last errors and loads the
// register defaults. A result waiting on m_tready does not block the next input beat;
// that beat's own result then waits in the final state until the port is free.
`default_nettype none

module three_axis_pid_position_controller_core #(
    parameter int unsigned KP_TURN      = 131072,
    parameter int unsigned KI_DT_TURN   = 7,
    parameter int unsigned KD_RATE_TURN = 6554,
    parameter int          FRAC_BITS    = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // [31:0] target_x, [63:32] target_y, [95:64] speed_x, [127:96] speed_y,
    // [159:128] yaw_rate
    input  wire logic [tappc_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // [15:0] drive_x, [31:16] drive_y, [48:32] drive_turn, [55:49] zero
    output logic [tappc_pkg::M_TDATA_W-1:0]            m_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [tappc_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [tappc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [tappc_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                       pready
);

    localparam int ONE_FX       = 1 << FRAC_BITS;
    localparam int INTEG_LIM    = (25 * ONE_FX + 50) / 100;
    localparam int OUT_LIM_XY   = (3 * ONE_FX + 5) / 10;
    localparam int OUT_LIM_TURN = (6 * ONE_FX + 5) / 10;
    localparam int DEAD_BAND    = (15 * ONE_FX + 500) / 1000;
    localparam int FW           = tappc_pkg::FIELD_W;

    localparam logic [tappc_pkg::GAIN_W-1:0] KP_T = tappc_pkg::GAIN_W'(KP_TURN);
    localparam logic [tappc_pkg::GAIN_W-1:0] KI_T = tappc_pkg::GAIN_W'(KI_DT_TURN);
    localparam logic [tappc_pkg::GAIN_W-1:0] KD_T = tappc_pkg::GAIN_W'(KD_RATE_TURN);
    localparam logic signed [31:0] OUT_LIM_XY_S = 32'(OUT_LIM_XY);
    localparam logic signed [31:0] OUT_LIM_T_S  = 32'(OUT_LIM_TURN);

    tappc_pkg::cfg_t   cfg;
    tappc_pkg::state_t state_reg;
    tappc_pkg::state_t state_next;

    logic signed [FW-1:0] target_x_reg;
    logic signed [FW-1:0] target_y_reg;
    logic signed [FW-1:0] yaw_rate_reg;
    logic signed [FW-1:0] pos_x_reg;
    logic signed [FW-1:0] pos_y_reg;
    logic signed [FW-1:0] err_x_reg;
    logic signed [FW-1:0] err_y_reg;
    logic signed [FW-1:0] err_t_reg;
    logic [tappc_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                            m_tvalid_reg;

    logic                 in_accept;
    logic                 ax_start;
    logic                 out_load;
    logic                 mul_x_done;
    logic                 mul_y_done;
    logic                 pos_done;
    logic signed [tappc_pkg::PROD_W-1:0] prod_x;
    logic signed [tappc_pkg::PROD_W-1:0] prod_y;
    logic [tappc_pkg::GAIN_W-1:0]        tick_gain;
    logic signed [FW-1:0] pos_x_next;
    logic signed [FW-1:0] pos_y_next;
    logic                 ax_done_x;
    logic                 ax_done_y;
    logic                 ax_done_t;
    logic signed [FW-1:0] ax_out_x;
    logic signed [FW-1:0] ax_out_y;
    logic signed [FW-1:0] ax_out_t;

    tappc_cfg u_cfg (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    assign in_accept = s_tvalid && s_tready;
    assign tick_gain = {{(tappc_pkg::GAIN_W - tappc_pkg::TICK_W){1'b0}}, cfg.tick_period};

    // Dead-reckoning multipliers: speed times tick period.
    tappc_ser_mul u_mul_pos_x (
        .aclk(aclk), .aresetn(aresetn), .start(in_accept),
        .a(s_tdata[2*FW +: FW]), .b(tick_gain), .done(mul_x_done), .product(prod_x)
    );

    tappc_ser_mul u_mul_pos_y (
        .aclk(aclk), .aresetn(aresetn), .start(in_accept),
        .a(s_tdata[3*FW +: FW]), .b(tick_gain), .done(mul_y_done), .product(prod_y)
    );

    // Both dead-reckoning products start together and finish together.
    assign pos_done = mul_x_done && mul_y_done;

    always_comb begin
        pos_x_next = tappc_pkg::sat32(64'(pos_x_reg) + (64'(prod_x) >>> FRAC_BITS));
        pos_y_next = tappc_pkg::sat32(64'(pos_y_reg) + (64'(prod_y) >>> FRAC_BITS));
    end

    // The three loops run side by side.
    tappc_axis #(
        .FRAC_BITS(FRAC_BITS), .OUT_LIM(OUT_LIM_XY),
        .INTEG_LIM(INTEG_LIM), .DEAD_BAND(DEAD_BAND)
    ) u_axis_x (
        .aclk(aclk), .aresetn(aresetn), .start(ax_start), .err(err_x_reg),
        .kp(cfg.kp_x), .ki(cfg.ki_dt_x), .kd(cfg.kd_rate_x),
        .done(ax_done_x), .out(ax_out_x)
    );

    tappc_axis #(
        .FRAC_BITS(FRAC_BITS), .OUT_LIM(OUT_LIM_XY),
        .INTEG_LIM(INTEG_LIM), .DEAD_BAND(DEAD_BAND)
    ) u_axis_y (
        .aclk(aclk), .aresetn(aresetn), .start(ax_start), .err(err_y_reg),
        .kp(cfg.kp_y), .ki(cfg.ki_dt_y), .kd(cfg.kd_rate_y),
        .done(ax_done_y), .out(ax_out_y)
    );

    tappc_axis #(
        .FRAC_BITS(FRAC_BITS), .OUT_LIM(OUT_LIM_TURN),
        .INTEG_LIM(INTEG_LIM), .DEAD_BAND(DEAD_BAND)
    ) u_axis_t (
        .aclk(aclk), .aresetn(aresetn), .start(ax_start), .err(err_t_reg),
        .kp(KP_T), .ki(KI_T), .kd(KD_T),
        .done(ax_done_t), .out(ax_out_t)
    );

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tappc_pkg::ST_IDLE:   if (s_tvalid) state_next = tappc_pkg::ST_DEAD;
            tappc_pkg::ST_DEAD:   if (pos_done) state_next = tappc_pkg::ST_ERR;
            tappc_pkg::ST_ERR:    state_next = tappc_pkg::ST_LAUNCH;
            tappc_pkg::ST_LAUNCH: state_next = tappc_pkg::ST_PID;
            tappc_pkg::ST_PID:    if (ax_done_x) state_next = tappc_pkg::ST_HOLD;
            tappc_pkg::ST_HOLD: begin
                if (!m_tvalid_reg || m_tready) state_next = tappc_pkg::ST_IDLE;
            end
            default:              state_next = tappc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready = (state_reg == tappc_pkg::ST_IDLE);
        ax_start = (state_reg == tappc_pkg::ST_LAUNCH);
        out_load = (state_reg == tappc_pkg::ST_HOLD) && (!m_tvalid_reg || m_tready);
    end

    // Control state, position estimates and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tappc_pkg::ST_IDLE;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if ((state_reg == tappc_pkg::ST_DEAD) && pos_done) begin
                pos_x_reg <= pos_x_next;
                pos_y_reg <= pos_y_next;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Input capture, error forming and result register.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            target_x_reg <= s_tdata[0 +: FW];
            target_y_reg <= s_tdata[FW +: FW];
            yaw_rate_reg <= s_tdata[4*FW +: FW];
        end
        if (state_reg == tappc_pkg::ST_ERR) begin
            err_x_reg <= tappc_pkg::sat32(64'(target_x_reg) - 64'(pos_x_reg));
            err_y_reg <= tappc_pkg::sat32(64'(target_y_reg) - 64'(pos_y_reg));
            err_t_reg <= tappc_pkg::sat32(64'sd0 - 64'(yaw_rate_reg));
        end
        if (out_load) begin
            m_tdata_reg <= {{tappc_pkg::M_PAD_W{1'b0}},
                            ax_out_t[tappc_pkg::DRIVE_TURN_W-1:0],
                            ax_out_y[tappc_pkg::DRIVE_XY_W-1:0],
                            ax_out_x[tappc_pkg::DRIVE_XY_W-1:0]};
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;

    // Dead-reckoning products finish only while the sequencer waits for them.
    a_pos_done_in_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_done |-> (state_reg == tappc_pkg::ST_DEAD))
        else $error("dead-reckoning multiply finished outside its state");

    // The three loops share one launch and must finish together.
    a_axes_in_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ax_done_x |-> (ax_done_y && ax_done_t && (state_reg == tappc_pkg::ST_PID)))
        else $error("PID loops out of step");

    // Loop outputs stay inside their clamp limits.
    a_out_limits: assert property (@(posedge aclk) disable iff (!aresetn)
        ax_done_x |-> ((ax_out_x <= OUT_LIM_XY_S) && (ax_out_x >= -OUT_LIM_XY_S) &&
                       (ax_out_y <= OUT_LIM_XY_S) && (ax_out_y >= -OUT_LIM_XY_S) &&
                       (ax_out_t <= OUT_LIM_T_S) && (ax_out_t >= -OUT_LIM_T_S)))
        else $error("loop output beyond clamp limit");

endmodule

`default_nettype wire
